[src/xtkd_pkg.sv]
// ----------------------------------------------------------------------------
// xtkd_pkg: shared types and constants for the xorshift table key derivation
// Secret word tables, pack length and the generator control struct.
// ----------------------------------------------------------------------------
package xtkd_pkg;

  // Key words per pack, capped at the largest pack the output can carry
  localparam int KEY_WORDS     = 8;
  localparam int MAX_WORDS     = 8;
  localparam int KEY_WORDS_EFF = (KEY_WORDS > MAX_WORDS) ? MAX_WORDS : KEY_WORDS;

  // Two draws per byte, four bytes per word
  localparam int DRAWS_PER_WORD = 8;
  localparam int DRAW_W         = 6;
  localparam int IDX_W          = 3;
  localparam logic [DRAW_W-1:0] LAST_DRAW = DRAW_W'(KEY_WORDS_EFF * DRAWS_PER_WORD - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(KEY_WORDS_EFF - 1);

  // Generator control from the sequencer
  typedef struct packed {
    logic load;
    logic step;
  } gen_ctrl_t;

  localparam logic [31:0] TABLE_A [64] = '{
    32'h476BC5E7, 32'h76DF4A26, 32'h2BD714E2, 32'h632623A5,
    32'hD36838ED, 32'h7583042F, 32'h32B3A6CE, 32'h301180A2,
    32'h63479874, 32'hB0EEF148, 32'h4144F37F, 32'h717EDD13,
    32'hA7C02D5F, 32'hDF535C64, 32'h1816AA04, 32'hC3E911A8,
    32'h07E6D14A, 32'hFAE665ED, 32'hE0A4AA9E, 32'hB271F407,
    32'hE57CCA4F, 32'hD2CBFF86, 32'h33AC5C1A, 32'h10867E0A,
    32'h42E43493, 32'h8CCBC746, 32'h1E82ECBC, 32'hFDE23A9C,
    32'h52A93E3D, 32'h617A7898, 32'h0753255C, 32'hDFF1DEC9,
    32'h310E0F37, 32'h1C4BA740, 32'h8E02AB06, 32'hDDBE8580,
    32'hC714785E, 32'h0B24EB7B, 32'hE6951F2F, 32'h728EBF81,
    32'hA10ABBBF, 32'h47F5244F, 32'hF96AD9DA, 32'h8B8472CD,
    32'hEE47B55B, 32'hA1E97980, 32'hF30B7FDA, 32'hFD230EE1,
    32'h7BF84A0E, 32'h705A2AFC, 32'h6685E6A1, 32'h98AAB220,
    32'h2B307047, 32'h551804EB, 32'h183A95BB, 32'h4531F3E8,
    32'hFDCB1756, 32'hF0387032, 32'h1F27AC7D, 32'h5AD014E2,
    32'h6508E3B3, 32'hF13D7C92, 32'hD7DA45D4, 32'hA01D9485
  };

  localparam logic [31:0] TABLE_B [64] = '{
    32'hDFD0A132, 32'h1537D7E5, 32'hC8B0F6D5, 32'h6C31FED3,
    32'hB7A1221A, 32'h9B9DC40C, 32'h44315579, 32'hF239E05A,
    32'h87E4D9AF, 32'h59EF5961, 32'hF5AF2DC9, 32'hD1521C02,
    32'h68405262, 32'h9864C589, 32'h98F5F8BE, 32'h0C90FE24,
    32'h9B3FC02A, 32'h31E4FD02, 32'hEC747B2D, 32'h5FC1C04E,
    32'h80D6B732, 32'h32BA6CB7, 32'h961A5683, 32'h33025098,
    32'hD5676789, 32'hAB622A5A, 32'hF651F93A, 32'h130D6D68,
    32'hEFFEDA48, 32'h24E2C2D3, 32'hEA89C5DD, 32'hF04AFA58,
    32'h767D3A19, 32'hBF67B888, 32'h54218F00, 32'h6F461AFF,
    32'h9A216E37, 32'h5861AAD0, 32'h3B44CEAE, 32'hCD6C9A42,
    32'h0610ECD2, 32'h2A894F76, 32'h23D72BE9, 32'h63FA2D93,
    32'h2ADC8A10, 32'hFB0E9F6A, 32'h3BE0CE91, 32'h80BB93A1,
    32'hDB8D8FF3, 32'h72E21DC7, 32'h93B0C670, 32'h2907C541,
    32'h3DBF1C6D, 32'h62D8924F, 32'h3205E36F, 32'h041C44D5,
    32'hDACB2490, 32'h01D905A9, 32'h6C8C579B, 32'hE3C54DC2,
    32'hF4583808, 32'h76459488, 32'h1E5F7C61, 32'h2876F360
  };

  // Byte lane of the selected secret word; lane 0 is the low byte
  function automatic logic [7:0] secret_byte(input logic       sel,
                                             input logic [5:0] idx,
                                             input logic [1:0] lane);
    logic [31:0] word;
    word = sel ? TABLE_B[idx] : TABLE_A[idx];
    unique case (lane)
      2'd0: secret_byte = word[7:0];
      2'd1: secret_byte = word[15:8];
      2'd2: secret_byte = word[23:16];
      2'd3: secret_byte = word[31:24];
      default: secret_byte = word[7:0];
    endcase
  endfunction

endpackage

[src/xorshift_table_key_derivation_core.sv]
// ----------------------------------------------------------------------------
// xorshift_table_key_derivation_core: key pack derivation from a 4-word seed
// Runs a xorshift128 generator and builds key bytes from secret table words.
// ----------------------------------------------------------------------------
//  channel | signals                                  | handshake
//  --------+------------------------------------------+--------------------------
//  seed    | seed_word0_i..seed_word3_i               | start high, busy low
//  key     | key_word_o, word_index_o, last_word_o    | key_valid_o, one cycle
//  config  | cfg_data_i (table_select)                | cfg_valid_i && cfg_ready_o
//
//  One generator draw per cycle. A word leaves in the cycle after its eighth
//  draw; busy drops with the last word and start may follow that cycle.
//  Reset is asynchronous, active low; no clearing pass.
//  The key channel cannot be stalled; results are strobed for one cycle.
// ----------------------------------------------------------------------------
module xorshift_table_key_derivation_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [31:0]                seed_word0_i,
  input  logic [31:0]                seed_word1_i,
  input  logic [31:0]                seed_word2_i,
  input  logic [31:0]                seed_word3_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_data_i,
  output logic                       key_valid_o,
  output logic [31:0]                key_word_o,
  output logic [xtkd_pkg::IDX_W-1:0] word_index_o,
  output logic                       last_word_o
);
  import xtkd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [DRAW_W-1:0] cnt_q, cnt_d;
  logic [5:0]        pick_q, pick_d;
  logic [23:0]       acc_q, acc_d;
  logic              tsel_q;
  logic              key_valid_q, key_valid_d;
  logic [31:0]       key_word_q;
  logic [IDX_W-1:0]  word_index_q;
  logic              last_word_q;
  logic              accept;
  logic              run;
  logic              word_done;
  logic [31:0]       draw;
  logic [7:0]        byte_val;
  gen_ctrl_t         gen_ctrl;

  assign accept = start && !busy;
  assign run    = (state_q == ST_RUN);
  assign busy   = run;

  // Table select register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsel_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tsel_q <= cfg_data_i;
    end
  end

  // Shared generator
  assign gen_ctrl.load = accept;
  assign gen_ctrl.step = run;

  xtkd_gen u_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (gen_ctrl),
    .seed0_i (seed_word0_i),
    .seed1_i (seed_word1_i),
    .seed2_i (seed_word2_i),
    .seed3_i (seed_word3_i),
    .draw_o  (draw)
  );

  // Even draws pick a table word, odd draws pick its byte lane
  assign byte_val  = secret_byte(tsel_q, pick_q, draw[31:30]);
  assign word_done = run && (cnt_q[2:0] == 3'd7);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pick_d      = pick_q;
    acc_d       = acc_q;
    key_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + DRAW_W'(1);
        if (!cnt_q[0]) begin
          pick_d = draw[31:26];
        end else begin
          acc_d = {acc_q[15:0], byte_val};
        end
        if (word_done) begin
          key_valid_d = 1'b1;
        end
        if (cnt_q == LAST_DRAW) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      key_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      key_valid_q <= key_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pick_q <= pick_d;
    acc_q  <= acc_d;
    if (word_done) begin
      key_word_q   <= {acc_q, byte_val};
      word_index_q <= cnt_q[DRAW_W-1:3];
      last_word_q  <= (cnt_q[DRAW_W-1:3] == LAST_IDX);
    end
  end

  assign key_valid_o  = key_valid_q;
  assign key_word_o   = key_word_q;
  assign word_index_o = word_index_q;
  assign last_word_o  = last_word_q;

endmodule

[src/xtkd_gen.sv]
// ----------------------------------------------------------------------------
// xtkd_gen: xorshift128 generator, one draw per step
// Holds the four-word state; load takes the seed, step advances one draw.
// ----------------------------------------------------------------------------
module xtkd_gen (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xtkd_pkg::gen_ctrl_t ctrl_i,
  input  logic [31:0]        seed0_i,
  input  logic [31:0]        seed1_i,
  input  logic [31:0]        seed2_i,
  input  logic [31:0]        seed3_i,
  output logic [31:0]        draw_o
);
  import xtkd_pkg::*;

  logic [31:0] s_q [4];
  logic [31:0] s_d [4];
  logic [31:0] t;

  // Next word: t ^ (t >> 8) ^ w ^ (w >> 19)
  assign t      = s_q[0] ^ (s_q[0] << 11);
  assign draw_o = t ^ (t >> 8) ^ s_q[3] ^ (s_q[3] >> 19);

  always_comb begin
    s_d = s_q;
    if (ctrl_i.load) begin
      s_d[0] = seed0_i;
      s_d[1] = seed1_i;
      s_d[2] = seed2_i;
      s_d[3] = seed3_i;
    end else if (ctrl_i.step) begin
      s_d[0] = s_q[1];
      s_d[1] = s_q[2];
      s_d[2] = s_q[3];
      s_d[3] = draw_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '{default: '0};
    end else begin
      s_q <= s_d;
    end
  end

endmodule

[src/xtkd_checker.sv]
// ----------------------------------------------------------------------------
// xtkd_checker: port-level checks for the key derivation core
// Watches busy, start and the key strobe over time; bound to the top level.
// ----------------------------------------------------------------------------
module xtkd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       key_valid_o,
  input logic [xtkd_pkg::IDX_W-1:0] word_index_o,
  input logic                       last_word_o
);
  import xtkd_pkg::*;

  // An accepted item keeps the core busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted item");

  // Words other than the last arrive while still busy
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_o && !last_word_o |-> busy)
    else $error("non-final word outside busy");

  // The core goes idle exactly with the last word
  a_fall_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> key_valid_o && last_word_o)
    else $error("busy dropped without last word");

  // Last word carries the final index
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_o && last_word_o |-> word_index_o == LAST_IDX)
    else $error("last word index mismatch");

  // Words are several draws apart, never back to back
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_o |=> !key_valid_o)
    else $error("key strobes back to back");

endmodule

bind xorshift_table_key_derivation_core xtkd_checker u_xtkd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .key_valid_o  (key_valid_o),
  .word_index_o (word_index_o),
  .last_word_o  (last_word_o)
);
